@@ hdl/vlpd_pkg.sv @@
// vlpd_pkg: shared types and constants for the length-prefixed deframer
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package vlpd_pkg;

  localparam int POSITION_BITS_DEF = 32;

  localparam int VALUE_W  = 64;
  localparam int SLEN_W   = 32;
  localparam int BYTE_W   = 8;

  localparam logic [31:0] SLEN_RESET   = 32'hFFFF_FFFF;
  localparam logic        RECORD_RESET = 1'b1;

  // prefix codes
  localparam logic [7:0] PFX_U16 = 8'hFD;
  localparam logic [7:0] PFX_U32 = 8'hFE;

  // integer bytes still due after the prefix, minus one
  localparam logic [2:0] INT_LEFT_U16 = 3'd1;
  localparam logic [2:0] INT_LEFT_U32 = 3'd3;
  localparam logic [2:0] INT_LEFT_U64 = 3'd7;

  // register indexes (paddr[2])
  localparam logic REG_STREAM_LENGTH = 1'b0;
  localparam logic REG_RECORD_MODE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_INT     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [SLEN_W-1:0] stream_length;
    logic              record_mode;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage

@@ hdl/vlpd_cfg.sv @@
// vlpd_cfg: apb-style register file holding stream length and record mode
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_cfg
  import vlpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [SLEN_W-1:0] slen_r, slen_nxt;
  logic              rec_r, rec_nxt;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    slen_nxt = slen_r;
    rec_nxt  = rec_r;
    if (wr_en) begin
      case (cfg_paddr[2])
        REG_STREAM_LENGTH: slen_nxt = cfg_pwdata;
        REG_RECORD_MODE:   rec_nxt  = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r <= SLEN_RESET;
      rec_r  <= RECORD_RESET;
    end else begin
      slen_r <= slen_nxt;
      rec_r  <= rec_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_STREAM_LENGTH: cfg_prdata = slen_r;
      REG_RECORD_MODE:   cfg_prdata = {31'd0, rec_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.stream_length = slen_r;
  assign cfg.record_mode   = rec_r;

endmodule

@@ hdl/vlpd_decode.sv @@
// vlpd_decode: parser state and single-pass next-state and result logic
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_decode
  import vlpd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [BYTE_W-1:0] in_byte,
  input  cfg_t              cfg,
  output logic              res_valid,
  output res_t              res
);

  localparam int CMP_W = (POSITION_BITS > SLEN_W) ? POSITION_BITS : SLEN_W;

  phase_t                   phase_r, phase_nxt;
  logic [2:0]               bl_r, bl_nxt;
  logic [2:0]               sh_r, sh_nxt;
  logic [VALUE_W-1:0]       acc_r, acc_nxt;
  logic [VALUE_W-1:0]       pl_r, pl_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     err_r, err_nxt;

  logic [CMP_W-1:0]   pos_ext, sl_ext, rem;
  logic [VALUE_W-1:0] acc_ins, fin_v;
  logic               pos_ge, pos_sat, fin;

  assign pos_ext = CMP_W'(pos_r);
  assign sl_ext  = CMP_W'(cfg.stream_length);
  assign pos_ge  = pos_ext >= sl_ext;
  assign pos_sat = &pos_r;
  // bytes left after this one; only used when position is below stream length
  assign rem     = sl_ext - pos_ext - CMP_W'(!pos_sat);
  assign acc_ins = VALUE_W'(in_byte) << {sh_r, 3'b000};

  always_comb begin
    phase_nxt = phase_r;
    bl_nxt    = bl_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    pl_nxt    = pl_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    res_valid = 1'b0;
    res.kind  = KIND_INT;
    res.value = '0;
    res.last  = 1'b0;
    fin       = 1'b0;
    fin_v     = '0;
    if (in_fire && !err_r) begin
      if (pos_ge) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_PREFIX;
        res_valid = 1'b1;
        res.kind  = KIND_ERR;
        res.last  = 1'b1;
      end else begin
        if (!pos_sat) pos_nxt = pos_r + 1'b1;
        case (phase_r)
          PH_PAYLOAD: begin
            pl_nxt    = pl_r - 64'd1;
            res_valid = 1'b1;
            res.kind  = KIND_BYTE;
            res.value = VALUE_W'(in_byte);
            res.last  = (pl_r == 64'd1);
            if (pl_r == 64'd1) phase_nxt = PH_PREFIX;
          end
          PH_INT: begin
            if (bl_r == 3'd0) begin
              fin   = 1'b1;
              fin_v = acc_r | acc_ins;
            end else begin
              acc_nxt = acc_r | acc_ins;
              bl_nxt  = bl_r - 3'd1;
              sh_nxt  = sh_r + 3'd1;
            end
          end
          PH_PREFIX: begin
            if (in_byte < PFX_U16) begin
              fin   = 1'b1;
              fin_v = VALUE_W'(in_byte);
            end else begin
              phase_nxt = PH_INT;
              sh_nxt    = 3'd0;
              acc_nxt   = '0;
              if (in_byte == PFX_U16)      bl_nxt = INT_LEFT_U16;
              else if (in_byte == PFX_U32) bl_nxt = INT_LEFT_U32;
              else                         bl_nxt = INT_LEFT_U64;
            end
          end
          default: phase_nxt = PH_PREFIX;
        endcase

        if (fin) begin
          phase_nxt = PH_PREFIX;
          bl_nxt    = 3'd0;
          sh_nxt    = 3'd0;
          acc_nxt   = '0;
          res_valid = 1'b1;
          if (!cfg.record_mode) begin
            res.value = fin_v;
            res.last  = 1'b1;
          end else if (fin_v > VALUE_W'(rem)) begin
            err_nxt  = 1'b1;
            res.kind = KIND_ERR;
            res.last = 1'b1;
          end else if (fin_v == '0) begin
            res.last = 1'b1;
          end else begin
            pl_nxt    = fin_v;
            phase_nxt = PH_PAYLOAD;
            res.value = fin_v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      bl_r    <= 3'd0;
      sh_r    <= 3'd0;
      acc_r   <= '0;
      pl_r    <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bl_r    <= bl_nxt;
      sh_r    <= sh_nxt;
      acc_r   <= acc_nxt;
      pl_r    <= pl_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ hdl/vlpd_skid.sv @@
// vlpd_skid: output register plus skid stage between decoder and result stream
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_skid
  import vlpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_res,
  output logic in_ready
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  // push only happens while the skid stage is empty
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_nxt       = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign in_ready  = !skid_valid_r;

endmodule

@@ hdl/varint_length_prefixed_deframer_core.sv @@
// compact varint deframer: one byte per item in, integers or payload bytes out
// each result is registered in the output register, or in the skid while that is held
// throughput: one byte per cycle while skid is empty; single-pass 64-bit length check
// a two-entry output stage keeps input ready while one result waits
// reset is synchronous active low: parser state cleared, registers to defaults
// depends on vlpd_pkg, vlpd_cfg, vlpd_decode, vlpd_skid
`timescale 1ns / 1ps

module varint_length_prefixed_deframer_core
  import vlpd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] value
  output logic        out_tlast,
  output logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  res_t res, out_res;
  logic res_valid, in_fire;

  assign in_fire = in_tvalid & in_tready;

  vlpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  vlpd_decode #(
    .POSITION_BITS (POSITION_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  vlpd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire & res_valid),
    .push_res  (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .in_ready  (in_tready)
  );

  assign out_tdata = out_res.value;
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.kind;

endmodule

@@ hdl/vlpd_checker.sv @@
// vlpd_checker: port-level assertions for the deframer, bound to the top level
// depends on vlpd_pkg and varint_length_prefixed_deframer_core
`timescale 1ns / 1ps

module vlpd_checker
  import vlpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // error item carries zero and closes the stream
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ERR) |-> (out_tdata == 64'd0 && out_tlast))
    else $error("error item with nonzero value or last low");

  // nothing follows a delivered error
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == KIND_ERR) |=> !out_tvalid)
    else $error("item after error");

  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_BYTE) |-> (out_tdata[63:8] == 56'd0))
    else $error("payload item wider than a byte");

  // input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output changed");

endmodule

bind varint_length_prefixed_deframer_core vlpd_checker u_vlpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ sim/tb_varint_length_prefixed_deframer_core.sv @@
// testbench for varint_length_prefixed_deframer_core: directed and random byte streams,
// randomized stalls on both sides, and every result checked against a behavioral predictor
// depends on vlpd_pkg and the deframer core rtl
`timescale 1ns / 1ps

module tb_varint_length_prefixed_deframer_core;
  import vlpd_pkg::*;

  localparam logic [7:0] PFX_U64_BYTE = 8'hFF;
  localparam int ITEM_TARGET = 2000;
  localparam int HOLD_AFTER = 100;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {FORM_BYTE, FORM_U16, FORM_U32, FORM_U64} form_e;

  class deframer_sb;
    logic [31:0] stream_len = SLEN_RESET;
    logic record_on = RECORD_RESET;
    phase_t ph = PH_PREFIX;
    logic [2:0] int_left = '0;
    logic [2:0] shift_idx = '0;
    logic [63:0] acc = '0;
    logic [63:0] pay_left = '0;
    logic [31:0] pos = '0;
    logic err = 1'b0;
    res_t pending_results[$];
    int mismatches = 0;

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void push(kind_t k, logic [63:0] v, logic l);
      res_t r;
      r.kind = k;
      r.value = v;
      r.last = l;
      pending_results.push_back(r);
    endfunction

    function void raise_error();
      err = 1'b1;
      ph = PH_PREFIX;
      push(KIND_ERR, '0, 1'b1);
    endfunction

    function void finish_int(logic [63:0] v);
      logic [63:0] remaining;
      ph = PH_PREFIX;
      int_left = '0;
      shift_idx = '0;
      acc = '0;
      if (!record_on) begin
        push(KIND_INT, v, 1'b1);
        return;
      end
      remaining = (stream_len > pos) ? 64'(stream_len - pos) : '0;
      if (v > remaining) raise_error();
      else if (v == 0) push(KIND_INT, '0, 1'b1);
      else begin
        pay_left = v;
        ph = PH_PAYLOAD;
        push(KIND_INT, v, 1'b0);
      end
    endfunction

    // predict the result of one accepted byte
    function void note_byte(logic [7:0] b);
      if (err) return;
      if (pos >= stream_len) begin
        raise_error();
        return;
      end
      if (pos != '1) pos++;
      case (ph)
        PH_PAYLOAD: begin
          pay_left--;
          if (pay_left == 0) ph = PH_PREFIX;
          push(KIND_BYTE, 64'(b), pay_left == 0);
        end
        PH_INT: begin
          acc |= 64'(b) << (8 * shift_idx);
          if (int_left == 0) finish_int(acc);
          else begin
            int_left--;
            shift_idx++;
          end
        end
        default: begin
          if (b < PFX_U16) finish_int(64'(b));
          else begin
            ph = PH_INT;
            shift_idx = '0;
            acc = '0;
            if (b == PFX_U16) int_left = INT_LEFT_U16;
            else if (b == PFX_U32) int_left = INT_LEFT_U32;
            else int_left = INT_LEFT_U64;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] k, logic [63:0] v, logic l);
      res_t r;
      if (pending_results.size() == 0) begin
        flag("unexpected result value", '0, v);
        return;
      end
      r = pending_results.pop_front();
      if (k !== r.kind) flag("kind", 64'(r.kind), 64'(k));
      if (v !== r.value) flag("value", r.value, v);
      if (l !== r.last) flag("last", 64'(r.last), 64'(l));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  deframer_sb sb = new;
  bit no_gaps = 1'b0;
  bit held = 1'b0;
  int items_sent = 0;
  int results_seen = 0;

  varint_length_prefixed_deframer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    items_sent++;
  endtask

  function automatic form_e min_form(logic [63:0] v);
    if (v < PFX_U16) return FORM_BYTE;
    if (v < 64'h1_0000) return FORM_U16;
    if (v < 64'h1_0000_0000) return FORM_U32;
    return FORM_U64;
  endfunction

  task automatic send_varint(logic [63:0] v, form_e form);
    int n;
    case (form)
      FORM_BYTE: n = 0;
      FORM_U16: n = 2;
      FORM_U32: n = 4;
      default: n = 8;
    endcase
    case (form)
      FORM_BYTE: send_byte(v[7:0]);
      FORM_U16: send_byte(PFX_U16);
      FORM_U32: send_byte(PFX_U32);
      default: send_byte(PFX_U64_BYTE);
    endcase
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_record(logic [63:0] len, form_e form);
    send_varint(len, form);
    for (longint i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // stop offering and let the block go quiet before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] d);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_verify(logic idx);
    logic [31:0] d;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    d = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_STREAM_LENGTH) begin
      if (d !== sb.stream_len) sb.flag("stream_length readback", 64'(sb.stream_len), 64'(d));
    end else if (d[0] !== sb.record_on) begin
      sb.flag("record_mode readback", 64'(sb.record_on), 64'(d[0]));
    end
  endtask

  task automatic cfg_set(logic idx, logic [31:0] d);
    cfg_write(idx, d);
    if (idx == REG_STREAM_LENGTH) sb.stream_len = d;
    else sb.record_on = d[0];
    cfg_verify(idx);
  endtask

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (!held && results_seen >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata, out_tlast);
      results_seen++;
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    form_e form;
    logic [63:0] v;
    int scenario;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_verify(REG_STREAM_LENGTH);
    cfg_verify(REG_RECORD_MODE);

    // record mode: empty record, short records in several prefix forms
    send_record(0, FORM_BYTE);
    send_record(1, FORM_BYTE);
    send_record(3, FORM_U16);
    send_record(1, FORM_U64);

    // mode switch in the middle of a payload: payload still completes
    send_varint(2, FORM_BYTE);
    send_byte(8'hA5);
    drain();
    cfg_set(REG_RECORD_MODE, 32'd0);
    send_byte(8'h5A);
    send_byte(8'h05);

    // value mode: field extremes and every prefix width
    send_byte(8'h00);
    send_byte(8'hFC);
    send_varint(64'hFFFF, FORM_U16);
    send_varint(64'hFFFF_FFFF, FORM_U32);
    send_varint('1, FORM_U64);
    drain();
    cfg_set(REG_RECORD_MODE, 32'd1);

    while (items_sent < ITEM_TARGET) begin
      drain();
      no_gaps = ($urandom_range(0, 3) == 0);
      cfg_set(REG_RECORD_MODE, 32'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) cfg_set(REG_STREAM_LENGTH, SLEN_RESET);
      else cfg_set(REG_STREAM_LENGTH, sb.pos + 10000 + $urandom_range(0, 1000));
      repeat (20) begin
        if (sb.record_on) begin
          v = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                              : $urandom_range(0, 12));
          send_record(v, form_e'($urandom_range(min_form(v), FORM_U64)));
        end else if ($urandom_range(0, 4) == 0) begin
          send_byte(8'($urandom));
        end else begin
          form = form_e'($urandom_range(FORM_BYTE, FORM_U64));
          case (form)
            FORM_BYTE: v = 64'($urandom_range(0, 252));
            FORM_U16: v = 64'($urandom_range(0, 65535));
            FORM_U32: v = 64'($urandom);
            default: v = {$urandom, $urandom};
          endcase
          send_varint(v, form);
        end
      end
      // finish any integer left open by noise so a mode change cannot see it
      while (sb.ph == PH_INT) send_byte(8'h00);
    end

    // closing error case; the error is sticky so only one fits in a run
    drain();
    no_gaps = 1'b0;
    scenario = $urandom_range(0, 2);
    if (scenario == 2) begin
      cfg_set(REG_RECORD_MODE, 32'($urandom_range(0, 1)));
      cfg_set(REG_STREAM_LENGTH, 32'd0);
      send_byte(8'($urandom));
    end else begin
      cfg_set(REG_RECORD_MODE, 32'd1);
      cfg_set(REG_STREAM_LENGTH, sb.pos + 5);
      if (scenario == 0) begin
        // length exactly fills the stream, then one byte too many
        send_record(4, FORM_BYTE);
        send_byte(8'($urandom));
      end else begin
        send_varint(5, form_e'($urandom_range(FORM_BYTE, FORM_U32)));
      end
    end
    // bytes after the error are dropped
    repeat (10) send_byte(8'($urandom));
    drain();
    cfg_set(REG_STREAM_LENGTH, 32'd0);
    repeat (5) send_byte(8'($urandom));

    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vlpd_pkg.sv
hdl/vlpd_cfg.sv
hdl/vlpd_decode.sv
hdl/vlpd_skid.sv
hdl/varint_length_prefixed_deframer_core.sv
hdl/vlpd_checker.sv
sim/tb_varint_length_prefixed_deframer_core.sv
